// ===== sv/dhf_pkg.sv =====
// Package for the 3x3 depth hole filler.
// Holds register indexes, fixed field widths, the controller state type and
// the command and status structs shared by the controller and the datapath.
package dhf_pkg;

    // Fixed widths of the stream words and of the configuration registers.
    localparam int DEPTH_BITS     = 16;
    localparam int WIDTH_REG_BITS = 11;
    localparam int HEIGHT_BITS    = 13;
    localparam int MIN_BITS       = 4;
    localparam int CFG_DATA_BITS  = 13;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CNT_BITS       = 4;

    // Geometry limits and reset values of the configuration registers.
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_MIN   = 13'd3;
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_MAX   = 13'd4096;
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [MIN_BITS-1:0]    MIN_RESET    = 4'd2;
    localparam int                     WIDTH_MIN    = 3;
    localparam int                     WIDTH_RESET  = 640;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_VALID    = 2'd2;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_SUM1,
        ST_SUM2,
        ST_SUM3,
        ST_DIV,
        ST_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic shift;
        logic sum1;
        logic sum2;
        logic sum3;
        logic div_step;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic skip;
        logic emit;
        logic fill;
        logic out_free;
    } t_status;

endpackage

// ===== sv/dhf_in_if.sv =====
// Input stream interface of the depth hole filler: one depth word per beat.
// Depends on dhf_pkg for the word width.
interface dhf_in_if;
    logic                            valid;
    logic                            ready;
    logic [dhf_pkg::DEPTH_BITS-1:0]  depth_in;
    logic                            drain;

    modport source (output valid, output depth_in, output drain, input ready);
    modport sink   (input valid, input depth_in, input drain, output ready);
endinterface

// ===== sv/dhf_out_if.sv =====
// Output stream interface of the depth hole filler: one filtered word per beat.
// Depends on dhf_pkg for the word width.
interface dhf_out_if;
    logic                            valid;
    logic                            ready;
    logic [dhf_pkg::DEPTH_BITS-1:0]  depth_out;
    logic                            was_filled;
    logic                            frame_end;

    modport source (output valid, output depth_out, output was_filled, output frame_end,
                    input ready);
    modport sink   (input valid, input depth_out, input was_filled, input frame_end,
                    output ready);
endinterface

// ===== sv/dhf_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module dhf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read in the same cycle; the read returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/dhf_ctrl.sv =====
// Controller of the depth hole filler: steps one word through line read,
// window shift, neighbor sum, optional division and the output register.
// Depends on dhf_pkg for the state type and the command and status structs.
module dhf_ctrl #(
    parameter int PIXEL_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  dhf_pkg::t_status  i_status,
    output logic              o_in_ready,
    output dhf_pkg::t_cmd     o_cmd
);

    // The divider makes one quotient bit per cycle over the whole sum.
    localparam int SUM_BITS  = PIXEL_BITS + 3;
    localparam int STEP_BITS = $clog2(SUM_BITS);
    localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(SUM_BITS - 1);

    dhf_pkg::t_state      r_state, n_state;
    logic [STEP_BITS-1:0] r_step, n_step;

    // State and step counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dhf_pkg::ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            dhf_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    if (!i_status.skip) begin
                        n_state = dhf_pkg::ST_SHIFT;
                    end
                end
            end
            dhf_pkg::ST_SHIFT: begin
                o_cmd.shift = 1'b1;
                n_state = i_status.emit ? dhf_pkg::ST_SUM1 : dhf_pkg::ST_IDLE;
            end
            dhf_pkg::ST_SUM1: begin
                o_cmd.sum1 = 1'b1;
                n_state = i_status.fill ? dhf_pkg::ST_SUM2 : dhf_pkg::ST_OUT;
            end
            dhf_pkg::ST_SUM2: begin
                o_cmd.sum2 = 1'b1;
                n_state = dhf_pkg::ST_SUM3;
            end
            dhf_pkg::ST_SUM3: begin
                o_cmd.sum3 = 1'b1;
                n_step  = '0;
                n_state = dhf_pkg::ST_DIV;
            end
            dhf_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = dhf_pkg::ST_OUT;
                end
            end
            dhf_pkg::ST_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = dhf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dhf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/dhf_dp.sv =====
// Datapath of the depth hole filler: position counters, two line stores,
// the 3x3 window, the neighbor adder tree, a restoring divider and the
// output register. Depends on dhf_pkg and dhf_ram.
module dhf_dp #(
    parameter int  MAX_WIDTH  = 1024,
    parameter int  PIXEL_BITS = 16,
    localparam int COL_BITS   = $clog2(MAX_WIDTH),
    localparam int WID_BITS   = (COL_BITS + 1 > dhf_pkg::WIDTH_REG_BITS) ?
                                COL_BITS + 1 : dhf_pkg::WIDTH_REG_BITS
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  dhf_pkg::t_cmd                           i_cmd,
    output dhf_pkg::t_status                        o_status,
    input  logic                                    i_restart,
    input  logic [WID_BITS-1:0]                     i_width,
    input  logic [dhf_pkg::HEIGHT_BITS-1:0]         i_height,
    input  logic [dhf_pkg::MIN_BITS-1:0]            i_min_valid,
    input  logic [dhf_pkg::DEPTH_BITS-1:0]          i_depth_in,
    input  logic                                    i_drain,
    input  logic                                    i_out_ready,
    output logic                                    o_out_valid,
    output logic [dhf_pkg::DEPTH_BITS-1:0]          o_depth_out,
    output logic                                    o_was_filled,
    output logic                                    o_frame_end
);

    localparam int SUM_BITS = PIXEL_BITS + 3;
    localparam int HB       = dhf_pkg::HEIGHT_BITS;
    localparam int CB       = dhf_pkg::CNT_BITS;

    logic [COL_BITS-1:0]   r_col, n_col;
    logic [HB-1:0]         r_row, n_row;
    logic [PIXEL_BITS-1:0] r_pix;
    logic [PIXEL_BITS-1:0] r_win [9];
    logic [PIXEL_BITS-1:0] r_pre;
    logic                  r_edge, r_interior, r_fend, r_fill;
    logic [PIXEL_BITS:0]   r_pair [4];
    logic [PIXEL_BITS+1:0] r_quad [2];
    logic [CB-1:0]         r_cnt;
    logic [SUM_BITS-1:0]   r_quo;
    logic [CB-1:0]         r_rem;
    logic                  r_out_valid;
    logic [PIXEL_BITS-1:0] r_out_depth;
    logic                  r_out_filled, r_out_fend;

    logic [PIXEL_BITS-1:0] mid_rd, top_rd;
    logic                  in_frame, emit, edge_col, interior, fend;
    logic [WID_BITS-1:0]   col_inc;
    logic                  col_wrap;
    logic [7:0]            nz;
    logic [CB-1:0]         cnt;
    logic                  fill;
    logic [CB:0]           rem_sh;
    logic                  q_bit;

    // Line stores: a holds the last row, b the row before it.
    dhf_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_line_a (
        .i_clk   (i_clk),
        .i_we    (i_cmd.shift),
        .i_waddr (r_col),
        .i_wdata (r_pix),
        .i_raddr (r_col),
        .o_rdata (mid_rd)
    );

    dhf_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_line_b (
        .i_clk   (i_clk),
        .i_we    (i_cmd.shift),
        .i_waddr (r_col),
        .i_wdata (mid_rd),
        .i_raddr (r_col),
        .o_rdata (top_rd)
    );

    // Position decode for the current slot.
    always_comb begin
        in_frame = r_row < i_height;
        emit     = (r_row >= HB'(2)) || ((r_row == HB'(1)) && (r_col != '0));
        edge_col = r_col == '0;
        interior = (r_col >= COL_BITS'(2)) && (r_row >= HB'(2)) && in_frame;
        fend     = edge_col && ({1'b0, r_row} == ({1'b0, i_height} + (HB+1)'(1)));
        col_inc  = WID_BITS'(r_col) + WID_BITS'(1);
        col_wrap = col_inc >= i_width;
        n_col    = col_wrap ? '0 : col_inc[COL_BITS-1:0];
        n_row    = col_wrap ? r_row + HB'(1) : r_row;
        if (fend) begin
            n_col = '0;
            n_row = '0;
        end
    end

    // Slot counters; a geometry write restarts the frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.shift) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Input capture; a word past the last row counts as zero padding.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pix <= in_frame ? i_depth_in[PIXEL_BITS-1:0] : '0;
        end
    end

    // Window shift and position flags for the pixel entering the window center.
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            r_pre      <= r_win[5];
            r_win[0]   <= r_win[1];
            r_win[1]   <= r_win[2];
            r_win[2]   <= top_rd;
            r_win[3]   <= r_win[4];
            r_win[4]   <= r_win[5];
            r_win[5]   <= mid_rd;
            r_win[6]   <= r_win[7];
            r_win[7]   <= r_win[8];
            r_win[8]   <= r_pix;
            r_edge     <= edge_col;
            r_interior <= interior;
            r_fend     <= fend;
        end
    end

    // Nonzero neighbors and the fill decision.
    always_comb begin
        nz[0] = r_win[0] != '0;
        nz[1] = r_win[1] != '0;
        nz[2] = r_win[2] != '0;
        nz[3] = r_win[3] != '0;
        nz[4] = r_win[5] != '0;
        nz[5] = r_win[6] != '0;
        nz[6] = r_win[7] != '0;
        nz[7] = r_win[8] != '0;
        cnt   = CB'($countones(nz));
        fill  = r_interior && (r_win[4] == '0) && (cnt != '0) && (cnt >= i_min_valid);
    end

    // Registered adder tree over the eight neighbors; zeros add nothing.
    always_ff @(posedge i_clk) begin
        if (i_cmd.sum1) begin
            r_pair[0] <= {1'b0, r_win[0]} + {1'b0, r_win[1]};
            r_pair[1] <= {1'b0, r_win[2]} + {1'b0, r_win[3]};
            r_pair[2] <= {1'b0, r_win[5]} + {1'b0, r_win[6]};
            r_pair[3] <= {1'b0, r_win[7]} + {1'b0, r_win[8]};
            r_cnt     <= cnt;
            r_fill    <= fill;
        end
        if (i_cmd.sum2) begin
            r_quad[0] <= {1'b0, r_pair[0]} + {1'b0, r_pair[1]};
            r_quad[1] <= {1'b0, r_pair[2]} + {1'b0, r_pair[3]};
        end
    end

    // Restoring division of the sum by the neighbor count, one bit a cycle.
    always_comb begin
        rem_sh = {r_rem, r_quo[SUM_BITS-1]};
        q_bit  = rem_sh >= {1'b0, r_cnt};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum3) begin
            r_quo <= {1'b0, r_quad[0]} + {1'b0, r_quad[1]};
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[SUM_BITS-2:0], q_bit};
            r_rem <= q_bit ? CB'(rem_sh - {1'b0, r_cnt}) : rem_sh[CB-1:0];
        end
    end

    // Output register; a new word loads only when the old one has gone.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_fill) begin
                r_out_depth <= r_quo[PIXEL_BITS-1:0];
            end else if (r_edge) begin
                r_out_depth <= r_pre;
            end else begin
                r_out_depth <= r_win[4];
            end
            r_out_filled <= r_fill;
            r_out_fend   <= r_fend;
        end
    end

    assign o_status.skip     = i_drain && in_frame;
    assign o_status.emit     = emit;
    assign o_status.fill     = fill;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_depth_out  = dhf_pkg::DEPTH_BITS'(r_out_depth);
    assign o_was_filled = r_out_filled;
    assign o_frame_end  = r_out_fend;

endmodule

// ===== sv/depth_hole_fill_3x3.sv =====
// 3x3 depth hole filler: one pass over a raster-order depth image.
// Input words arrive on i_px (valid/ready); results leave on o_px through an
// output register, so a new word is taken while the last result waits.
// Border pixels pass unchanged; an inner zero pixel becomes the truncated mean
// of its nonzero neighbors when enough of them are nonzero.
// Results lag the input by image_width+1 words: after the last pixel of a
// frame send image_width+1 words with drain set; frame_end marks the last one.
// A drain word inside a frame is taken and dropped.
// A word with no result passes the shift step only; a plain result adds a sum step and
// the output step, and a filled hole adds two more sum steps and the one-bit-per-cycle
// divider over the PIXEL_BITS+3 bit neighbor sum, which sets the longest case.
// A result shows on o_px.valid once its word has passed these steps and loaded the
// output register. When the receiver stalls the output register holds its word; the
// block keeps taking words until the next one with a result, which then waits.
// Reset (i_rst_n low, synchronous) empties the output, restarts the frame and
// sets width 640 (MAX_WIDTH if smaller), height 480, threshold 2.
// Writing image_width or image_height restarts the frame; write only while idle.
// Line store contents are not cleared and need no clearing pass.
module depth_hole_fill_3x3 #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    dhf_in_if.sink                                i_px,
    dhf_out_if.source                             o_px,
    input  logic                                  i_cfg_we,
    input  logic [dhf_pkg::CFG_IDX_BITS-1:0]      i_cfg_idx,
    input  logic [dhf_pkg::CFG_DATA_BITS-1:0]     i_cfg_data
);

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int WID_BITS = (COL_BITS + 1 > dhf_pkg::WIDTH_REG_BITS) ?
                              COL_BITS + 1 : dhf_pkg::WIDTH_REG_BITS;
    localparam logic [WID_BITS-1:0] WIDTH_LO  = WID_BITS'(dhf_pkg::WIDTH_MIN);
    localparam logic [WID_BITS-1:0] WIDTH_HI  = WID_BITS'(MAX_WIDTH);
    localparam logic [WID_BITS-1:0] WIDTH_RST = (MAX_WIDTH < dhf_pkg::WIDTH_RESET) ?
                                                WID_BITS'(MAX_WIDTH) :
                                                WID_BITS'(dhf_pkg::WIDTH_RESET);

    logic [WID_BITS-1:0]              r_width, n_width;
    logic [dhf_pkg::HEIGHT_BITS-1:0]  r_height, n_height;
    logic [dhf_pkg::MIN_BITS-1:0]     r_min_valid;
    logic [WID_BITS-1:0]              wr_width;
    logic [dhf_pkg::HEIGHT_BITS-1:0]  wr_height;
    logic                             restart;
    dhf_pkg::t_cmd                    cmd;
    dhf_pkg::t_status                 status;

    // Clamp written geometry into the supported range.
    always_comb begin
        wr_width  = WID_BITS'(i_cfg_data[dhf_pkg::WIDTH_REG_BITS-1:0]);
        wr_height = i_cfg_data[dhf_pkg::HEIGHT_BITS-1:0];
        if (wr_width < WIDTH_LO) begin
            n_width = WIDTH_LO;
        end else if (wr_width > WIDTH_HI) begin
            n_width = WIDTH_HI;
        end else begin
            n_width = wr_width;
        end
        if (wr_height < dhf_pkg::HEIGHT_MIN) begin
            n_height = dhf_pkg::HEIGHT_MIN;
        end else if (wr_height > dhf_pkg::HEIGHT_MAX) begin
            n_height = dhf_pkg::HEIGHT_MAX;
        end else begin
            n_height = wr_height;
        end
        restart = i_cfg_we && ((i_cfg_idx == dhf_pkg::REG_IMAGE_WIDTH) ||
                               (i_cfg_idx == dhf_pkg::REG_IMAGE_HEIGHT));
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= WIDTH_RST;
            r_height    <= dhf_pkg::HEIGHT_RESET;
            r_min_valid <= dhf_pkg::MIN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dhf_pkg::REG_IMAGE_WIDTH:  r_width     <= n_width;
                dhf_pkg::REG_IMAGE_HEIGHT: r_height    <= n_height;
                dhf_pkg::REG_MIN_VALID:    r_min_valid <= i_cfg_data[dhf_pkg::MIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer.
    dhf_ctrl #(.PIXEL_BITS(PIXEL_BITS)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_px.valid),
        .i_status   (status),
        .o_in_ready (i_px.ready),
        .o_cmd      (cmd)
    );

    // Window, line stores, adder tree, divider and output register.
    dhf_dp #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_restart    (restart),
        .i_width      (r_width),
        .i_height     (r_height),
        .i_min_valid  (r_min_valid),
        .i_depth_in   (i_px.depth_in),
        .i_drain      (i_px.drain),
        .i_out_ready  (o_px.ready),
        .o_out_valid  (o_px.valid),
        .o_depth_out  (o_px.depth_out),
        .o_was_filled (o_px.was_filled),
        .o_frame_end  (o_px.frame_end)
    );

endmodule
